### hdl/owcm_pkg.sv
// Shared types, constants and command codes for the omni wheel command mixer.
// No dependencies; imported by every RTL module of the block except owcm_checker.
`default_nettype none

package owcm_pkg;

   localparam int CMD_W      = 8;
   localparam int STEP_W     = 7;
   localparam int SPEED_W    = 10;
   localparam int VEL_W      = 11;
   localparam int DUTY_W     = 9;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 10;
   localparam int NUM_WHEELS = 4;

   localparam int SPEED_RESET = 700;
   localparam int STEP_RESET  = 10;
   localparam int LIMIT_RESET = 700;

   // Mixing: n = 707*(+-f +-l) + 1000*t, duty = trunc(249*n / (1000*FULL_SCALE_RPM))
   localparam int FULL_SCALE_RPM = 700;
   localparam int COEF_DIAG      = 707;
   localparam int COEF_UNIT      = 1000;
   localparam int DUTY_MAX       = 249;
   localparam int SCALE_DIV      = COEF_UNIT * FULL_SCALE_RPM;

   // Speed math: speed +- step plus a sign bit
   localparam int SPD_CALC_W = SPEED_W + 2;
   // Diagonal pair sum (+-f +-l)
   localparam int PAIR_W = VEL_W + 1;
   // Mixed wheel sum: |n| <= 707*2046 + 1000*1023 < 2^23
   localparam int MIX_W = 24;
   // Magnitude below the saturation threshold
   localparam int MAG_W = $clog2(SCALE_DIV);

   // Reciprocal for trunc(249*m / SCALE_DIV), exact for every m < SCALE_DIV
   localparam int RECIP_SHIFT = 2 * MAG_W;
   localparam longint unsigned RECIP_VAL =
      (longint'(DUTY_MAX) * (longint'(1) << RECIP_SHIFT) + longint'(SCALE_DIV) - 1)
      / longint'(SCALE_DIV);
   localparam int RECIP_W = $clog2(RECIP_VAL + 1);
   localparam int PROD_W  = MAG_W + RECIP_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_FORWARD  = 8'h46,  // F
      CMD_BACKWARD = 8'h42,  // B
      CMD_LEFT     = 8'h4C,  // L
      CMD_RIGHT    = 8'h52,  // R
      CMD_TURN_POS = 8'h47,  // G
      CMD_TURN_NEG = 8'h49,  // I
      CMD_STOP     = 8'h53,  // S
      CMD_SPEED_UP = 8'h69,  // i
      CMD_SPEED_DN = 8'h64   // d
   } cmd_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SPEED_STEP  = 1'b0,
      CSR_SPEED_LIMIT = 1'b1
   } csr_addr_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] fwd;
      logic signed [VEL_W-1:0] lat;
      logic signed [VEL_W-1:0] turn;
   } vec_type;

   typedef struct packed {
      logic fwd_neg;
      logic lat_neg;
   } mix_sign_type;

   typedef struct packed {
      logic             neg;
      logic             sat;
      logic [MAG_W-1:0] mag;
   } wheel_term_type;

   // Coupling signs of the forward and lateral terms, wheels one to four
   localparam mix_sign_type WHEEL_SIGN [NUM_WHEELS] = '{
      '{fwd_neg: 1'b1, lat_neg: 1'b0},
      '{fwd_neg: 1'b1, lat_neg: 1'b1},
      '{fwd_neg: 1'b0, lat_neg: 1'b1},
      '{fwd_neg: 1'b0, lat_neg: 1'b0}
   };

endpackage

`default_nettype wire

### hdl/omni_wheel_command_mixer_top.sv
// An accepted req transaction passes the vector, wheel-sum and output registers before rsp_valid.
// Throughput: one transaction per cycle; req_stall rises only when every
// stage (vector, wheel sum, output) holds data and rsp_stall is high.
// Reset (synchronous): pipeline emptied, speed 700, vector zero,
// speed_step 10, speed_limit 700.
// Depends on owcm_pkg, owcm_state, owcm_wheel_sum, owcm_duty_scale.
`default_nettype none

module omni_wheel_command_mixer_top (
   input  wire                                  clock,
   input  wire                                  reset,
   // command transactions
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire [owcm_pkg::CMD_W-1:0]            req_command_byte,
   // wheel duty transactions
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [owcm_pkg::DUTY_W-1:0]   rsp_wheel_one_duty,
   output logic signed [owcm_pkg::DUTY_W-1:0]   rsp_wheel_two_duty,
   output logic signed [owcm_pkg::DUTY_W-1:0]   rsp_wheel_three_duty,
   output logic signed [owcm_pkg::DUTY_W-1:0]   rsp_wheel_four_duty,
   // configuration writes
   input  wire                                  csr_wr_en,
   input  wire [owcm_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire [owcm_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import owcm_pkg::*;

   // Stage valids; each stage moves when the next one is empty or moving.
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic out_valid_ff;
   logic out_ready;
   logic s2_ready;
   logic s1_ready;
   logic req_accept;

   // Stage 1: velocity vector as it stands after this transaction
   vec_type        vec_next;
   vec_type        s1_vec_ff;
   // Stage 2: per-wheel sign / saturation / magnitude
   wheel_term_type term_in  [NUM_WHEELS];
   wheel_term_type s2_term_ff [NUM_WHEELS];
   // Output stage
   logic signed [DUTY_W-1:0] duty_in  [NUM_WHEELS];
   logic signed [DUTY_W-1:0] duty_ff  [NUM_WHEELS];

   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;

   // Command decode: state advances at accept time, so the next command sees it
   owcm_state u_state (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .cmd       (req_command_byte),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .vec_next  (vec_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_vec_ff <= vec_next;
      end
   end

   // Four lanes: mixing sum, then reciprocal scaling, a register after each
   for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
      owcm_wheel_sum u_sum (
         .vec  (s1_vec_ff),
         .sgn  (WHEEL_SIGN[w]),
         .term (term_in[w])
      );

      owcm_duty_scale u_scale (
         .term (s2_term_ff[w]),
         .duty (duty_in[w])
      );

      always_ff @(posedge clock) begin
         if (s1_valid_ff && s2_ready) begin
            s2_term_ff[w] <= term_in[w];
         end
         if (s2_valid_ff && out_ready) begin
            duty_ff[w] <= duty_in[w];
         end
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_wheel_one_duty   = duty_ff[0];
   assign rsp_wheel_two_duty   = duty_ff[1];
   assign rsp_wheel_three_duty = duty_ff[2];
   assign rsp_wheel_four_duty  = duty_ff[3];

endmodule

`default_nettype wire

### hdl/owcm_state.sv
// Command decode with the speed and velocity-vector state and the CSR registers.
// Depends on owcm_pkg.
`default_nettype none

module owcm_state (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             accept,
   input  wire [owcm_pkg::CMD_W-1:0]       cmd,
   input  wire                             csr_wr_en,
   input  wire [owcm_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire [owcm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output owcm_pkg::vec_type               vec_next
);
   import owcm_pkg::*;

   logic [STEP_W-1:0]  step_ff;
   logic [SPEED_W-1:0] limit_ff;
   logic [SPEED_W-1:0] speed_ff;
   logic [SPEED_W-1:0] speed_in;
   vec_type            vec_ff;
   vec_type            vec_in;

   logic signed [SPD_CALC_W-1:0] spd_sum;
   logic signed [SPD_CALC_W-1:0] spd_clamp;
   logic signed [VEL_W-1:0]      spd_pos;
   logic signed [VEL_W-1:0]      spd_neg;

   always_comb begin
      spd_pos = signed'({1'b0, speed_ff});
      spd_neg = -spd_pos;
      vec_in  = vec_ff;
      spd_sum = signed'({2'b00, speed_ff});
      unique case (cmd)
         CMD_FORWARD:  vec_in = '{fwd: spd_pos, lat: '0, turn: '0};
         CMD_BACKWARD: vec_in = '{fwd: spd_neg, lat: '0, turn: '0};
         CMD_LEFT:     vec_in = '{fwd: '0, lat: spd_pos, turn: '0};
         CMD_RIGHT:    vec_in = '{fwd: '0, lat: spd_neg, turn: '0};
         CMD_TURN_POS: vec_in = '{fwd: '0, lat: '0, turn: spd_pos};
         CMD_TURN_NEG: vec_in = '{fwd: '0, lat: '0, turn: spd_neg};
         CMD_STOP:     vec_in = '0;
         CMD_SPEED_UP: spd_sum = signed'({2'b00, speed_ff}) + signed'(SPD_CALC_W'(step_ff));
         CMD_SPEED_DN: spd_sum = signed'({2'b00, speed_ff}) - signed'(SPD_CALC_W'(step_ff));
         default: ;
      endcase
      // clamp applies on every transaction, against the current limit
      if (spd_sum > signed'({2'b00, limit_ff})) begin
         spd_clamp = signed'({2'b00, limit_ff});
      end else if (spd_sum < 0) begin
         spd_clamp = '0;
      end else begin
         spd_clamp = spd_sum;
      end
      speed_in = spd_clamp[SPEED_W-1:0];
   end

   assign vec_next = vec_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= SPEED_W'(SPEED_RESET);
         vec_ff   <= '0;
      end else if (accept) begin
         speed_ff <= speed_in;
         vec_ff   <= vec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_W'(STEP_RESET);
         limit_ff <= SPEED_W'(LIMIT_RESET);
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_SPEED_STEP:  step_ff  <= csr_wdata[STEP_W-1:0];
            CSR_SPEED_LIMIT: limit_ff <= csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

### hdl/owcm_wheel_sum.sv
// One wheel's mixing sum: sign, saturation flag and magnitude of the scaled velocity.
// Depends on owcm_pkg.
`default_nettype none

module owcm_wheel_sum (
   input  wire owcm_pkg::vec_type      vec,
   input  wire owcm_pkg::mix_sign_type sgn,
   output owcm_pkg::wheel_term_type    term
);
   import owcm_pkg::*;

   logic signed [PAIR_W-1:0] fwd_ext;
   logic signed [PAIR_W-1:0] lat_ext;
   logic signed [PAIR_W-1:0] pair;
   logic signed [MIX_W-1:0]  mix;
   logic        [MIX_W-1:0]  mix_abs;

   always_comb begin
      fwd_ext = PAIR_W'(vec.fwd);
      lat_ext = PAIR_W'(vec.lat);
      pair    = (sgn.fwd_neg ? -fwd_ext : fwd_ext) + (sgn.lat_neg ? -lat_ext : lat_ext);
      mix     = signed'(MIX_W'(pair)) * signed'(MIX_W'(COEF_DIAG))
              + signed'(MIX_W'(vec.turn)) * signed'(MIX_W'(COEF_UNIT));
      mix_abs = mix[MIX_W-1] ? MIX_W'(-mix) : MIX_W'(mix);
      term.neg = mix[MIX_W-1];
      term.sat = (mix_abs >= MIX_W'(SCALE_DIV));
      term.mag = mix_abs[MAG_W-1:0];
   end

endmodule

`default_nettype wire

### hdl/owcm_duty_scale.sv
// Scales one wheel magnitude to a signed PWM compare value with saturation.
// Depends on owcm_pkg.
`default_nettype none

module owcm_duty_scale (
   input  wire owcm_pkg::wheel_term_type       term,
   output logic signed [owcm_pkg::DUTY_W-1:0]  duty
);
   import owcm_pkg::*;

   logic [PROD_W-1:0]   prod;
   logic [DUTY_W-2:0]   quot;
   logic [DUTY_W-2:0]   mag_duty;
   logic signed [DUTY_W-1:0] duty_pos;

   always_comb begin
      // reciprocal multiply, exact truncation below the saturation threshold
      prod     = PROD_W'(term.mag) * PROD_W'(RECIP_VAL);
      quot     = prod[RECIP_SHIFT +: DUTY_W-1];
      mag_duty = term.sat ? (DUTY_W-1)'(DUTY_MAX) : quot;
      duty_pos = signed'({1'b0, mag_duty});
      duty     = term.neg ? -duty_pos : duty_pos;
   end

endmodule

`default_nettype wire

### hdl/owcm_checker.sv
// Port-level checks for the omni wheel command mixer, bound to the top level.
// Depends on omni_wheel_command_mixer_top port names only.
`default_nettype none

module owcm_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_stall,
   input wire              rsp_valid,
   input wire              rsp_stall,
   input wire signed [8:0] rsp_wheel_one_duty,
   input wire signed [8:0] rsp_wheel_two_duty,
   input wire signed [8:0] rsp_wheel_three_duty,
   input wire signed [8:0] rsp_wheel_four_duty
);

   // a stalled result transaction keeps its valid and its wheel one and four duties
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_wheel_one_duty)
         && $stable(rsp_wheel_four_duty))
      else $error("rsp transaction changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // no back-pressure at the input unless the output is stalled
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req_stall without rsp_stall");

   // duties stay within the saturation bounds
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_wheel_one_duty   >= -9'sd249 && rsp_wheel_one_duty   <= 9'sd249 &&
         rsp_wheel_two_duty   >= -9'sd249 && rsp_wheel_two_duty   <= 9'sd249 &&
         rsp_wheel_three_duty >= -9'sd249 && rsp_wheel_three_duty <= 9'sd249 &&
         rsp_wheel_four_duty  >= -9'sd249 && rsp_wheel_four_duty  <= 9'sd249)
      else $error("wheel duty out of range");

endmodule

bind omni_wheel_command_mixer_top owcm_checker u_owcm_checker (.*);

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for omni_wheel_command_mixer_top: command transactions in,
// predicted four-wheel duty sets checked in order. Needs owcm_pkg and the block's RTL.
`default_nettype none

module tb;
   import owcm_pkg::*;

   localparam int PIPE_LATENCY   = 3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 900;
   localparam int RANDOM_PHASES  = 9;

   // four 9-bit duties, index 0 = wheel one
   typedef logic [NUM_WHEELS-1:0][DUTY_W-1:0] duty_quad_type;

   localparam cmd_type KNOWN_CMDS [9] = '{
      CMD_FORWARD, CMD_BACKWARD, CMD_LEFT, CMD_RIGHT, CMD_TURN_POS,
      CMD_TURN_NEG, CMD_STOP, CMD_SPEED_UP, CMD_SPEED_DN
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [CMD_W-1:0]       req_command_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic signed [DUTY_W-1:0] rsp_wheel_one_duty;
   logic signed [DUTY_W-1:0] rsp_wheel_two_duty;
   logic signed [DUTY_W-1:0] rsp_wheel_three_duty;
   logic signed [DUTY_W-1:0] rsp_wheel_four_duty;
   logic                   csr_wr_en        = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr         = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;

   // shadow copy of the block's state and registers
   int track_speed;
   int track_fwd;
   int track_lat;
   int track_turn;
   int track_step;
   int track_limit;

   duty_quad_type expected_duties [$];
   int            mismatch_count = 0;

   // idling controls, flipped per test phase
   bit tx_quiet = 1'b0;
   bit rx_quiet = 1'b0;
   int tx_burst_left = 0;

   int idle_cycles = 0;

   omni_wheel_command_mixer_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command_byte     (req_command_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_wheel_one_duty   (rsp_wheel_one_duty),
      .rsp_wheel_two_duty   (rsp_wheel_two_duty),
      .rsp_wheel_three_duty (rsp_wheel_three_duty),
      .rsp_wheel_four_duty  (rsp_wheel_four_duty),
      .csr_wr_en            (csr_wr_en),
      .csr_addr             (csr_addr),
      .csr_wdata            (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // Duty prediction
   // ---------------------------------------------------------------

   // One wheel: n = sf*707*f + sl*707*l + 1000*t, then two truncating
   // divisions and a clamp to +-249.
   function automatic logic [DUTY_W-1:0] wheel_duty(int sf, int sl);
      longint n;
      longint scaled;
      longint duty;
      n = longint'(sf) * COEF_DIAG * track_fwd
        + longint'(sl) * COEF_DIAG * track_lat
        + longint'(COEF_UNIT) * track_turn;
      scaled = (longint'(DUTY_MAX) * n) / COEF_UNIT;
      duty   = scaled / FULL_SCALE_RPM;
      if (duty > DUTY_MAX)
         duty = DUTY_MAX;
      if (duty < -DUTY_MAX)
         duty = -DUTY_MAX;
      return duty[DUTY_W-1:0];
   endfunction

   // Apply one command to the shadow state and queue the duty set it yields.
   task automatic mix_command(input logic [CMD_W-1:0] cmd);
      int            next_speed;
      duty_quad_type duties;
      next_speed = track_speed;
      case (cmd)
         CMD_FORWARD: begin
            track_fwd = track_speed; track_lat = 0; track_turn = 0;
         end
         CMD_BACKWARD: begin
            track_fwd = -track_speed; track_lat = 0; track_turn = 0;
         end
         CMD_LEFT: begin
            track_fwd = 0; track_lat = track_speed; track_turn = 0;
         end
         CMD_RIGHT: begin
            track_fwd = 0; track_lat = -track_speed; track_turn = 0;
         end
         CMD_TURN_POS: begin
            track_fwd = 0; track_lat = 0; track_turn = track_speed;
         end
         CMD_TURN_NEG: begin
            track_fwd = 0; track_lat = 0; track_turn = -track_speed;
         end
         CMD_STOP: begin
            track_fwd = 0; track_lat = 0; track_turn = 0;
         end
         CMD_SPEED_UP: next_speed = track_speed + track_step;
         CMD_SPEED_DN: next_speed = track_speed - track_step;
         default: ;
      endcase
      // clamp runs on every command, after the motion bytes used the old speed
      if (next_speed > track_limit)
         next_speed = track_limit;
      if (next_speed < 0)
         next_speed = 0;
      track_speed = next_speed;

      duties[0] = wheel_duty(-1,  1);
      duties[1] = wheel_duty(-1, -1);
      duties[2] = wheel_duty( 1, -1);
      duties[3] = wheel_duty( 1,  1);
      expected_duties.push_back(duties);
   endtask

   // ---------------------------------------------------------------
   // Command sender: bursts with random gaps
   // ---------------------------------------------------------------
   task automatic send_command(input logic [CMD_W-1:0] cmd);
      int gap;
      if (tx_burst_left == 0) begin
         tx_burst_left = $urandom_range(1, 24);
         if (!tx_quiet) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      tx_burst_left--;
      req_command_byte <= cmd;
      req_valid        <= 1'b1;
      // transaction completes at the first edge with stall low
      do @(posedge clock); while (req_stall);
      mix_command(cmd);
   endtask

   // Hold the sender off until every queued duty set is out, then let the
   // pipeline settle.
   task automatic wait_all_duties();
      req_valid <= 1'b0;
      while (expected_duties.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // Register writes only happen with the block drained.
   task automatic write_csr(input csr_addr_type addr, input int data);
      wait_all_duties();
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (addr == CSR_SPEED_STEP)
         track_step = data & ((1 << STEP_W) - 1);
      else
         track_limit = data & ((1 << SPEED_W) - 1);
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Receiver stall pattern: runs of free, stalled or coin-flip cycles
   // ---------------------------------------------------------------
   int stall_left = 0;
   int stall_kind = 0;

   always @(posedge clock) begin : rx_pattern
      logic nxt;
      if (stall_left == 0) begin
         stall_kind <= $urandom_range(0, 2);
         stall_left <= $urandom_range(1, 16);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_kind)
         0:       nxt = 1'b0;
         1:       nxt = 1'b1;
         default: nxt = 1'($urandom_range(0, 1));
      endcase
      if (rx_quiet)
         nxt = 1'b0;
      rsp_stall <= nxt;
   end

   // ---------------------------------------------------------------
   // Result checker: in-order compare against the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin : duty_check
      duty_quad_type want;
      duty_quad_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_wheel_four_duty, rsp_wheel_three_duty,
                rsp_wheel_two_duty, rsp_wheel_one_duty};
         if (expected_duties.size() == 0) begin
            $display("%0t: unexpected duty transaction %0d %0d %0d %0d", $time,
                     $signed(got[0]), $signed(got[1]), $signed(got[2]), $signed(got[3]));
            mismatch_count++;
         end else begin
            want = expected_duties.pop_front();
            for (int k = 0; k < NUM_WHEELS; k++) begin
               if (got[k] !== want[k]) begin
                  $display("%0t: wheel %0d duty expected %0d actual %0d", $time, k + 1,
                           $signed(want[k]), $signed(got[k]));
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: too long without any transaction on either channel
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Vector is zero after reset; unknown bytes at both ends of the range.
   task automatic test_reset_state();
      send_command(8'h00);
      send_command(8'hFF);
   endtask

   // Every motion byte at full reset speed, then stop.
   task automatic test_motion_bytes();
      send_command(CMD_FORWARD);
      send_command(CMD_BACKWARD);
      send_command(CMD_LEFT);
      send_command(CMD_RIGHT);
      send_command(CMD_TURN_POS);
      send_command(CMD_TURN_NEG);
      send_command(CMD_STOP);
   endtask

   // Default step down and up; the raises bring the speed back to the limit.
   task automatic test_speed_steps();
      send_command(CMD_SPEED_DN);
      send_command(CMD_SPEED_DN);
      send_command(CMD_FORWARD);
      send_command(CMD_SPEED_UP);
      send_command(CMD_SPEED_UP);
      send_command(CMD_TURN_NEG);
   endtask

   // Lowered limit: the next motion byte still uses the old speed, the one
   // after sees the clamp. Limit 0 stalls the robot.
   task automatic test_speed_limit();
      write_csr(CSR_SPEED_LIMIT, 50);
      send_command(CMD_TURN_POS);
      send_command(CMD_TURN_POS);
      write_csr(CSR_SPEED_LIMIT, 0);
      send_command(CMD_LEFT);
      send_command(CMD_LEFT);
   endtask

   // Zero step leaves the speed alone; a big step down stops at zero.
   task automatic test_step_edges();
      write_csr(CSR_SPEED_LIMIT, 700);
      write_csr(CSR_SPEED_STEP, 0);
      send_command(CMD_SPEED_UP);
      send_command(CMD_SPEED_DN);
      send_command(CMD_BACKWARD);
      write_csr(CSR_SPEED_STEP, 100);
      send_command(CMD_SPEED_UP);
      send_command(CMD_SPEED_DN);
      send_command(CMD_SPEED_DN);
      send_command(CMD_RIGHT);
      write_csr(CSR_SPEED_STEP, 1);
      send_command(CMD_SPEED_UP);
      send_command(CMD_TURN_POS);
   endtask

   // Random phases, each with its own register setting and idling style.
   task automatic test_random_commands();
      int per_phase;
      int pick;
      int value;
      logic [CMD_W-1:0] cmd;
      per_phase = RANDOM_ITEMS / RANDOM_PHASES;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick = $urandom_range(0, 3);
         value = (pick == 0) ? 1 : (pick == 1) ? 100 : $urandom_range(1, 100);
         write_csr(CSR_SPEED_STEP, value);
         pick = $urandom_range(0, 5);
         value = (pick == 0) ? 0 : (pick < 3) ? 700 : $urandom_range(0, 700);
         write_csr(CSR_SPEED_LIMIT, value);
         // phases 1 and 5 send flat out, phases 2, 5 and 8 receive flat out
         tx_quiet = (phase % 4 == 1);
         rx_quiet = (phase % 3 == 2);
         for (int n = 0; n < per_phase; n++) begin
            if ($urandom_range(0, 9) < 7)
               cmd = KNOWN_CMDS[4'($urandom_range(0, 8))];
            else
               cmd = CMD_W'($urandom_range(0, 255));
            // now and then drain fully before the next command
            if ($urandom_range(0, 63) == 0)
               wait_all_duties();
            send_command(cmd);
         end
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   initial begin
      track_speed = SPEED_RESET;
      track_fwd   = 0;
      track_lat   = 0;
      track_turn  = 0;
      track_step  = STEP_RESET;
      track_limit = LIMIT_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_motion_bytes();
      test_speed_steps();
      test_speed_limit();
      test_step_edges();
      test_random_commands();

      wait_all_duties();
      if (expected_duties.size() != 0) begin
         $display("%0t: %0d duty sets never arrived", $time, expected_duties.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

### omni_wheel_command_mixer_top.f
hdl/owcm_pkg.sv
hdl/owcm_state.sv
hdl/owcm_wheel_sum.sv
hdl/owcm_duty_scale.sv
hdl/omni_wheel_command_mixer_top.sv
hdl/owcm_checker.sv
sim/tb.sv
